FILE: design/rrps_pkg.sv
// shared types and constants of the round-robin packet scheduler
package rrps_pkg;

   localparam int TimeWidth   = 32;
   localparam int QueueWidth  = 2;
   localparam int IdWidth     = 16;
   localparam int LenWidth    = 16;
   localparam int RateWidth   = 32;
   localparam int ReqDataWidth = 72;
   localparam int RspDataWidth = 56;

   localparam logic ReqArrival = 1'b0;
   localparam logic ReqFlush   = 1'b1;

   localparam logic StatusSent    = 1'b0;
   localparam logic StatusDropped = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic load;      // latch the request word
      logic pick;      // search round robin and read the head entry
      logic mul;       // service time product
      logic serve;     // send the head packet
      logic enq;       // store or drop the arriving packet
      logic set_idle;  // link goes idle
      logic finish;    // release the held result as last
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_flush;
      logic any_queued;
      logic serve_cond;
      logic drop;
      logic pend_valid;
      logic out_free;
   } status_type;

endpackage

FILE: design/rrps_ctrl.sv
// sequencing state machine of the scheduler
module rrps_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  rrps_pkg::status_type stat,
   output rrps_pkg::cmd_type  cmd
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_CHECK  = 7'b0000010,
      ST_SEARCH = 7'b0000100,
      ST_MUL    = 7'b0001000,
      ST_SERVE  = 7'b0010000,
      ST_ENQ    = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      blocked;

   assign blocked    = stat.pend_valid && !stat.out_free;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.is_flush) begin
               if (stat.any_queued) begin
                  state_in = ST_SEARCH;
               end else begin
                  cmd.set_idle = 1'b1;
                  state_in     = ST_DONE;
               end
            end else if (stat.serve_cond) begin
               if (stat.any_queued) begin
                  state_in = ST_SEARCH;
               end else begin
                  // everything sent: idle, then re-check
                  cmd.set_idle = 1'b1;
               end
            end else begin
               state_in = ST_ENQ;
            end
         end
         ST_SEARCH: begin
            cmd.pick = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SERVE;
         end
         ST_SERVE: begin
            if (!blocked) begin
               cmd.serve = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_ENQ: begin
            if (!(stat.drop && blocked)) begin
               cmd.enq  = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!blocked) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/rrps_dp.sv
// queues, link timing and result registers of the scheduler
module rrps_dp #(
   parameter int NUM_QUEUES  = 4,
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [rrps_pkg::RateWidth-1:0]      csr_wr_data,
   input  logic                                req_tuser,
   input  logic [rrps_pkg::ReqDataWidth-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rrps_pkg::RspDataWidth-1:0]   rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   input  rrps_pkg::cmd_type                   cmd,
   output rrps_pkg::status_type                stat
);

   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int DW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int AW = QW + DW;
   localparam int TW = rrps_pkg::TimeWidth;
   localparam int PW = rrps_pkg::LenWidth + rrps_pkg::RateWidth;
   localparam int EW = rrps_pkg::IdWidth + rrps_pkg::LenWidth;

   // request word
   logic                             flush_ff;
   logic [TW-1:0]                    arrival_ff;
   logic [rrps_pkg::QueueWidth-1:0]  qnum_ff;
   logic [rrps_pkg::IdWidth-1:0]     id_ff;
   logic [rrps_pkg::LenWidth-1:0]    len_ff;

   logic [rrps_pkg::RateWidth-1:0]   tpl_ff;
   logic [DW-1:0]                    head_ff [NUM_QUEUES];
   logic [CW-1:0]                    cnt_ff [NUM_QUEUES];
   logic [QW-1:0]                    rr_ff;
   logic [TW-1:0]                    link_ff;
   logic                             idle_ff;
   logic [EW-1:0]                    mem [2**AW];
   logic [EW-1:0]                    rd_ff;
   logic [QW-1:0]                    sel_ff;
   logic [PW-1:0]                    prod_ff;

   // held result, released once the next one is known
   logic                             pend_valid_ff;
   logic [TW-1:0]                    pend_time_ff;
   logic [rrps_pkg::IdWidth-1:0]     pend_id_ff;
   logic [rrps_pkg::QueueWidth-1:0]  pend_q_ff;
   logic                             pend_st_ff;

   logic                             out_valid_ff;
   logic [TW-1:0]                    out_time_ff;
   logic [rrps_pkg::IdWidth-1:0]     out_id_ff;
   logic [rrps_pkg::QueueWidth-1:0]  out_q_ff;
   logic                             out_st_ff;
   logic                             out_last_ff;

   logic [QW-1:0]                    found_q;
   logic                             any_queued;
   logic [QW-1:0]                    arr_q;
   logic                             drop;
   logic [SW-1:0]                    slot_sum;
   logic [DW-1:0]                    slot;
   logic [TW:0]                      sum;
   logic [TW-1:0]                    new_time;
   logic                             out_free;
   logic                             push;
   logic [QW-1:0]                    rr_next;

   // first non-empty queue at or after the round-robin pointer
   always_comb begin
      int idx;
      found_q    = '0;
      any_queued = 1'b0;
      for (int h = NUM_QUEUES - 1; h >= 0; h--) begin
         idx = int'(rr_ff) + h;
         if (idx >= NUM_QUEUES) begin
            idx = idx - NUM_QUEUES;
         end
         if (cnt_ff[QW'(idx)] != '0) begin
            found_q    = QW'(idx);
            any_queued = 1'b1;
         end
      end
   end

   assign arr_q    = QW'(qnum_ff);
   assign drop     = (32'(qnum_ff) >= NUM_QUEUES) ||
                     (cnt_ff[arr_q] >= CW'(QUEUE_DEPTH));
   always_comb begin
      slot_sum = SW'(head_ff[arr_q]) + SW'(cnt_ff[arr_q]);
      if (slot_sum >= SW'(QUEUE_DEPTH)) begin
         slot_sum = slot_sum - SW'(QUEUE_DEPTH);
      end
   end
   assign slot     = slot_sum[DW-1:0];

   assign sum      = {1'b0, link_ff} + {1'b0, prod_ff[PW-1:16]};
   assign new_time = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
   assign rr_next  = (sel_ff == QW'(NUM_QUEUES - 1)) ? '0 : sel_ff + 1'b1;

   assign out_free = !out_valid_ff || rsp_tready;
   assign push     = cmd.serve || (cmd.enq && drop);

   assign stat.is_flush   = flush_ff;
   assign stat.any_queued = any_queued;
   assign stat.serve_cond = !idle_ff && (arrival_ff >= link_ff);
   assign stat.drop       = drop;
   assign stat.pend_valid = pend_valid_ff;
   assign stat.out_free   = out_free;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         flush_ff   <= req_tuser;
         arrival_ff <= req_tdata[31:0];
         qnum_ff    <= req_tdata[33:32];
         id_ff      <= req_tdata[49:34];
         len_ff     <= req_tdata[65:50];
      end
      if (cmd.pick) begin
         sel_ff <= found_q;
         rd_ff  <= mem[{found_q, head_ff[found_q]}];
      end
      if (cmd.mul) begin
         prod_ff <= PW'(rd_ff[rrps_pkg::LenWidth-1:0]) * PW'(tpl_ff);
      end
      if (cmd.enq && !drop) begin
         mem[{arr_q, slot}] <= {id_ff, len_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpl_ff  <= rrps_pkg::RateWidth'(32'd16777216);
         rr_ff   <= '0;
         link_ff <= '0;
         idle_ff <= 1'b1;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            tpl_ff <= csr_wr_data;
         end
         if (cmd.set_idle) begin
            idle_ff <= 1'b1;
         end
         if (cmd.serve) begin
            link_ff         <= new_time;
            rr_ff           <= rr_next;
            cnt_ff[sel_ff]  <= cnt_ff[sel_ff] - 1'b1;
            head_ff[sel_ff] <= (head_ff[sel_ff] == DW'(QUEUE_DEPTH - 1)) ?
                               '0 : head_ff[sel_ff] + 1'b1;
         end
         if (cmd.enq && !drop) begin
            cnt_ff[arr_q] <= cnt_ff[arr_q] + 1'b1;
            if (idle_ff) begin
               link_ff <= arrival_ff;
               idle_ff <= 1'b0;
            end
         end
      end
   end

   // result word staging
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if ((push || cmd.finish) && pend_valid_ff) begin
            out_valid_ff <= 1'b1;
            out_time_ff  <= pend_time_ff;
            out_id_ff    <= pend_id_ff;
            out_q_ff     <= pend_q_ff;
            out_st_ff    <= pend_st_ff;
            out_last_ff  <= cmd.finish;
         end
         if (cmd.finish) begin
            pend_valid_ff <= 1'b0;
         end
         if (cmd.serve) begin
            pend_valid_ff <= 1'b1;
            pend_time_ff  <= new_time;
            pend_id_ff    <= rd_ff[EW-1:rrps_pkg::LenWidth];
            pend_q_ff     <= rrps_pkg::QueueWidth'(sel_ff);
            pend_st_ff    <= rrps_pkg::StatusSent;
         end else if (cmd.enq && drop) begin
            pend_valid_ff <= 1'b1;
            pend_time_ff  <= '0;
            pend_id_ff    <= id_ff;
            pend_q_ff     <= qnum_ff;
            pend_st_ff    <= rrps_pkg::StatusDropped;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_q_ff, out_id_ff, out_time_ff};
   assign rsp_tuser  = out_st_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

FILE: design/round_robin_packet_scheduler_unit.sv
// round-robin packet scheduler: one result word per sent or dropped packet
// steps: a check after the accept, then per packet sent the states search, multiply and serve
// (search with head read, 16x32 multiply, saturating add); going idle on an arrival adds a re-check
// one item in flight; the next is taken once all its result words are staged
// reset: synchronous, queues empty, link idle at time 0, time_per_length = 256 ticks
// queue store contents are not cleared; only counted entries are read
module round_robin_packet_scheduler_unit #(
   parameter int NUM_QUEUES  = 4,
   parameter int QUEUE_DEPTH = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [rrps_pkg::RateWidth-1:0]     csr_wr_data,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // arrival_time, queue_number, packet_id, packet_length, zero pad
   input  logic [rrps_pkg::ReqDataWidth-1:0]  req_tdata,
   // req_type
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // finish_time, out_packet_id, out_queue, zero pad
   output logic [rrps_pkg::RspDataWidth-1:0]  rsp_tdata,
   // status
   output logic                               rsp_tuser,
   output logic                               rsp_tlast
);

   rrps_pkg::cmd_type    cmd;
   rrps_pkg::status_type stat;

   rrps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rrps_dp #(
      .NUM_QUEUES  (NUM_QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

FILE: design/rrps_checker.sv
// port-level checks of the scheduler and their binding
module rrps_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [rrps_pkg::RspDataWidth-1:0]  rsp_tdata,
   input logic                               rsp_tuser
);

   // output word holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // a dropped packet never carries a finish time
   a_drop_time: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == rrps_pkg::StatusDropped |-> rsp_tdata[31:0] == '0)
      else $error("drop result with nonzero finish time");

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while previous item still in work");

   a_reset_out: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind round_robin_packet_scheduler_unit rrps_checker u_rrps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: test/rrps_checker.sv
// checker: watches the scheduler's channels, predicts result words and compares them
module rrps_scoreboard (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [rrps_pkg::RateWidth-1:0]    csr_wr_data,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [rrps_pkg::ReqDataWidth-1:0] req_tdata,
   input  logic                              req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [rrps_pkg::RspDataWidth-1:0] rsp_tdata,
   input  logic                              rsp_tuser,
   input  logic                              rsp_tlast,
   output int                                fail_count,
   output int                                pending,
   output int                                words_seen,
   output int                                drops_seen
);

   localparam int NQ = 4;
   localparam int DEPTH = 8;
   localparam int EW = rrps_pkg::IdWidth + rrps_pkg::LenWidth;

   typedef struct packed {
      logic [rrps_pkg::TimeWidth-1:0]  finish;
      logic [rrps_pkg::IdWidth-1:0]    id;
      logic [rrps_pkg::QueueWidth-1:0] queue;
      logic                            status;
      logic                            last;
   } sched_word_type;

   sched_word_type expected_words[$];

   logic [rrps_pkg::RateWidth-1:0] rate;
   logic [EW-1:0] fifo_mem[NQ][DEPTH];
   int unsigned head[NQ];
   int unsigned count[NQ];
   int unsigned rr;
   logic [rrps_pkg::TimeWidth-1:0] link_finish;
   bit link_idle;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   // sends the next round-robin packet; returns 0 when every queue is empty
   function automatic bit send_next(ref sched_word_type words[$]);
      int unsigned q;
      logic [EW-1:0] e;
      logic [63:0] inc;
      logic [63:0] sum;
      sched_word_type w;
      q = rr % NQ;
      for (int h = 0; h < NQ; h++) begin
         if (count[q] != 0) begin
            e = fifo_mem[q][head[q]];
            inc = (64'(e[rrps_pkg::LenWidth-1:0]) * 64'(rate)) >> 16;
            sum = 64'(link_finish) + inc;
            link_finish = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            head[q] = (head[q] + 1) % DEPTH;
            count[q]--;
            rr = (q + 1) % NQ;
            w.finish = link_finish;
            w.id = e[EW-1:rrps_pkg::LenWidth];
            w.queue = q[1:0];
            w.status = rrps_pkg::StatusSent;
            w.last = 1'b0;
            words.push_back(w);
            return 1'b1;
         end
         q = (q + 1) % NQ;
      end
      return 1'b0;
   endfunction

   task automatic predict_item(input logic kind,
                               input logic [rrps_pkg::ReqDataWidth-1:0] d);
      logic [rrps_pkg::TimeWidth-1:0] at;
      logic [rrps_pkg::QueueWidth-1:0] qn;
      logic [rrps_pkg::IdWidth-1:0] id;
      logic [rrps_pkg::LenWidth-1:0] len;
      sched_word_type words[$];
      sched_word_type w;
      int unsigned slot;
      at = d[31:0];
      qn = d[33:32];
      id = d[49:34];
      len = d[65:50];
      if (kind == rrps_pkg::ReqFlush) begin
         while (send_next(words)) ;
         link_idle = 1'b1;
      end else begin
         while (!link_idle && at >= link_finish) begin
            if (!send_next(words)) link_idle = 1'b1;
         end
         if (count[qn] >= DEPTH) begin
            w.finish = '0;
            w.id = id;
            w.queue = qn;
            w.status = rrps_pkg::StatusDropped;
            w.last = 1'b0;
            words.push_back(w);
         end else begin
            slot = (head[qn] + count[qn]) % DEPTH;
            fifo_mem[qn][slot] = {id, len};
            count[qn]++;
            if (link_idle) begin
               link_finish = at;
               link_idle = 1'b0;
            end
         end
      end
      if (words.size() > 0) words[words.size()-1].last = 1'b1;
      foreach (words[i]) expected_words.push_back(words[i]);
   endtask

   always @(posedge clock) begin
      sched_word_type got;
      sched_word_type exp_w;
      if (reset) begin
         rate <= 32'd16777216;
         for (int q = 0; q < NQ; q++) begin
            head[q] = 0;
            count[q] = 0;
         end
         rr = 0;
         link_finish = '0;
         link_idle = 1'b1;
         expected_words.delete();
      end else begin
         if (csr_wr_en) rate <= csr_wr_data;
         if (req_tvalid && req_tready) predict_item(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            words_seen <= words_seen + 1;
            got.finish = rsp_tdata[31:0];
            got.id = rsp_tdata[47:32];
            got.queue = rsp_tdata[49:48];
            got.status = rsp_tuser;
            got.last = rsp_tlast;
            if (got.status == rrps_pkg::StatusDropped) drops_seen <= drops_seen + 1;
            if (expected_words.size() == 0) begin
               report_mismatch("result word with nothing expected");
            end else begin
               exp_w = expected_words.pop_front();
               if (got.finish !== exp_w.finish)
                  report_mismatch($sformatf("finish_time %h, want %h",
                                            got.finish, exp_w.finish));
               if (got.id !== exp_w.id)
                  report_mismatch($sformatf("packet id %h, want %h", got.id, exp_w.id));
               if (got.queue !== exp_w.queue)
                  report_mismatch($sformatf("queue %0d, want %0d", got.queue, exp_w.queue));
               if (got.status !== exp_w.status)
                  report_mismatch($sformatf("status %b, want %b", got.status, exp_w.status));
               if (got.last !== exp_w.last)
                  report_mismatch($sformatf("last %b, want %b", got.last, exp_w.last));
            end
         end
      end
      pending <= expected_words.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
      words_seen = 0;
      drops_seen = 0;
   end

endmodule

FILE: test/tb.sv
// testbench top: drives the round-robin packet scheduler and gives the verdict
module tb;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [rrps_pkg::RateWidth-1:0] csr_wr_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [rrps_pkg::ReqDataWidth-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [rrps_pkg::RspDataWidth-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;

   int fail_count;
   int pending;
   int words_seen;
   int drops_seen;
   int sender_idle_pct = 17;
   int receiver_idle_pct = 75;
   bit hold_off = 1'b0;
   int items_sent = 0;
   int flushes_sent = 0;
   longint cycle_count = 0;
   logic [rrps_pkg::TimeWidth-1:0] now_time = '0;

   round_robin_packet_scheduler_unit dut (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast
   );

   rrps_scoreboard chk (
      .clock, .reset, .csr_wr_en, .csr_wr_data,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .fail_count, .pending, .words_seen, .drops_seen
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 600000) begin
         $display("timeout with %0d result words outstanding", pending);
         $display("** round_robin_packet_scheduler_unit: FAILED **");
         $finish;
      end
   end

   // receiver side: random stalls unless held off
   always @(posedge clock) begin
      if (reset || hold_off) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // valid stays up after the accept so the next word can follow directly
   task automatic send_word(input logic kind, input logic [rrps_pkg::TimeWidth-1:0] at,
                            input logic [1:0] qn, input logic [15:0] id,
                            input logic [15:0] len);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {6'b0, len, id, qn, at};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (kind == rrps_pkg::ReqFlush) flushes_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0 || req_tvalid) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_rate(input logic [rrps_pkg::RateWidth-1:0] v);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // one random item: mostly arrivals moving forward in time, some flushes
   task automatic random_item();
      int r;
      r = $urandom_range(99);
      if (r < 6) begin
         send_word(rrps_pkg::ReqFlush, $urandom, 2'($urandom), 16'($urandom),
                   16'($urandom));
      end else begin
         if (r < 10) now_time = $urandom;
         else now_time = now_time + $urandom_range(2000);
         send_word(rrps_pkg::ReqArrival, now_time, 2'($urandom), 16'($urandom),
                   ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(12)));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, flush on empty, full queue drop, saturation
      send_word(rrps_pkg::ReqFlush, 32'd0, 2'd0, 16'd0, 16'd0);
      send_word(rrps_pkg::ReqArrival, 32'd0, 2'd0, 16'h0000, 16'h0000);
      send_word(rrps_pkg::ReqArrival, 32'd0, 2'd1, 16'hFFFF, 16'hFFFF);
      send_word(rrps_pkg::ReqArrival, 32'd100, 2'd2, 16'h1234, 16'd5);
      send_word(rrps_pkg::ReqArrival, 32'hFFFF_FFFF, 2'd3, 16'hABCD, 16'd1);
      send_word(rrps_pkg::ReqArrival, 32'hFFFF_FFFF, 2'd0, 16'h0001, 16'd2);
      for (int i = 0; i < 10; i++)
         send_word(rrps_pkg::ReqArrival, 32'd10, 2'd3, 16'(i), 16'd7);
      send_word(rrps_pkg::ReqFlush, 32'd0, 2'd0, 16'd0, 16'd0);
      send_word(rrps_pkg::ReqArrival, 32'hFFFF_FF00, 2'd2, 16'h5555, 16'hFFFF);
      send_word(rrps_pkg::ReqArrival, 32'hFFFF_FF00, 2'd1, 16'hAAAA, 16'hFFFF);
      send_word(rrps_pkg::ReqFlush, 32'hFFFF_FFFF, 2'd3, 16'hFFFF, 16'hFFFF);

      write_rate(32'hFFFF_FFFF);
      send_word(rrps_pkg::ReqArrival, 32'd0, 2'd0, 16'h0F0F, 16'hFFFF);
      send_word(rrps_pkg::ReqArrival, 32'd0, 2'd1, 16'hF0F0, 16'h0003);
      send_word(rrps_pkg::ReqFlush, 32'd0, 2'd0, 16'd0, 16'd0);
      write_rate(32'd0);
      send_word(rrps_pkg::ReqArrival, 32'd5, 2'd2, 16'h0042, 16'd9);
      send_word(rrps_pkg::ReqArrival, 32'd5, 2'd2, 16'h0043, 16'd9);
      send_word(rrps_pkg::ReqArrival, 32'd6, 2'd3, 16'h0044, 16'd9);

      // receiver held off while the sender keeps offering
      hold_off = 1'b1;
      fork
         repeat (300) @(posedge clock);
         begin
            for (int i = 0; i < 30; i++) random_item();
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      join_any
      repeat (300) @(posedge clock);
      hold_off = 1'b0;
      wait fork;
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 75 : 0;
         receiver_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 17 : 0;
         case (phase)
            0: write_rate(32'd16777216);
            1: write_rate(32'h0000_4000 + $urandom_range(32'h0010_0000));
            default: write_rate($urandom);
         endcase
         for (int i = 0; i < 125; i++) random_item();
         wait_drained();
      end

      wait_drained();
      $display("sent %0d items (%0d flushes), checked %0d result words, %0d drops",
               items_sent, flushes_sent, words_seen, drops_seen);
      if (fail_count == 0) $display("** round_robin_packet_scheduler_unit: PASSED **");
      else $display("** round_robin_packet_scheduler_unit: FAILED **");
      $finish;
   end

endmodule

FILE: sim.f
design/rrps_pkg.sv
design/rrps_ctrl.sv
design/rrps_dp.sv
design/round_robin_packet_scheduler_unit.sv
design/rrps_checker.sv
test/rrps_checker.sv
test/tb.sv
